// ----- sv/haptic_pattern_player_assert.svh -----
// assertion macros for the haptic pattern player
`ifndef HAPTIC_PATTERN_PLAYER_ASSERT_SVH
`define HAPTIC_PATTERN_PLAYER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define HPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/hpp_pkg.sv -----
`default_nettype none

package hpp_pkg;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_LOAD        = 3'd1,
    ACT_PLAY_LOADED = 3'd2,
    ACT_PLAY_PRESET = 3'd3,
    ACT_CANCEL      = 3'd4,
    ACT_SUSPEND     = 3'd5,
    ACT_RESUME      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    PRE_TICK   = 3'd0,
    PRE_SHORT  = 3'd1,
    PRE_DOUBLE = 3'd2,
    PRE_LONG   = 3'd3,
    PRE_TRIPLE = 3'd4
  } preset_t;

  localparam logic [2:0]  PRESET_COUNT = 3'd5;
  localparam logic [6:0]  DUTY_MAX     = 7'd100;
  localparam logic [15:0] GUARD_RESET  = 16'd3300;

  localparam logic [15:0] TICK_ON_MS    = 16'd30;
  localparam logic [15:0] SHORT_ON_MS   = 16'd100;
  localparam logic [15:0] DOUBLE_ON_MS  = 16'd80;
  localparam logic [15:0] DOUBLE_OFF_MS = 16'd120;
  localparam logic [15:0] LONG_ON_MS    = 16'd600;
  localparam logic [15:0] TRIPLE_ON_MS  = 16'd60;
  localparam logic [15:0] TRIPLE_OFF_MS = 16'd80;

  // step word: on time in the upper half, off time in the lower half
  function automatic logic [31:0] preset_step(input logic [2:0] pid, input logic [4:0] slot);
    logic [31:0] s;
    s = '0;
    case (preset_t'(pid))
      PRE_TICK:   if (slot == 5'd0) s = {TICK_ON_MS, 16'd0};
      PRE_SHORT:  if (slot == 5'd0) s = {SHORT_ON_MS, 16'd0};
      PRE_DOUBLE: begin
        if (slot == 5'd0) s = {DOUBLE_ON_MS, DOUBLE_OFF_MS};
        else if (slot == 5'd1) s = {DOUBLE_ON_MS, 16'd0};
      end
      PRE_LONG:   if (slot == 5'd0) s = {LONG_ON_MS, 16'd0};
      PRE_TRIPLE: begin
        if (slot == 5'd0 || slot == 5'd1) s = {TRIPLE_ON_MS, TRIPLE_OFF_MS};
        else if (slot == 5'd2) s = {TRIPLE_ON_MS, 16'd0};
      end
      default:    s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] preset_len(input logic [2:0] pid);
    logic [7:0] n;
    n = 8'd0;
    case (preset_t'(pid))
      PRE_TICK:   n = 8'd1;
      PRE_SHORT:  n = 8'd1;
      PRE_DOUBLE: n = 8'd2;
      PRE_LONG:   n = 8'd1;
      PRE_TRIPLE: n = 8'd3;
      default:    n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- sv/hpp_ifs.sv -----
`default_nettype none

interface hpp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  step_index;
  logic [15:0] on_time_ms;
  logic [15:0] off_time_ms;
  logic [7:0]  step_count;
  logic [2:0]  preset_id;
  logic [7:0]  intensity;
  logic [15:0] supply_mv;

  modport source (
    output valid, action, step_index, on_time_ms, off_time_ms, step_count, preset_id,
    intensity, supply_mv,
    input ready
  );
  modport sink (
    input valid, action, step_index, on_time_ms, off_time_ms, step_count, preset_id,
    intensity, supply_mv,
    output ready
  );
endinterface

interface hpp_rsp_if;
  logic        valid;
  logic        ready;
  logic [6:0]  duty_level;
  logic        busy_res;
  logic        suspended;
  logic        accepted;
  logic [6:0]  last_intensity;
  logic [15:0] accept_total;
  logic [15:0] refuse_total;

  modport source (
    output valid, duty_level, busy_res, suspended, accepted, last_intensity, accept_total,
    refuse_total,
    input ready
  );
  modport sink (
    input valid, duty_level, busy_res, suspended, accepted, last_intensity, accept_total,
    refuse_total,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/hpp_step_search.sv -----
`default_nettype none

// lowest set bit of a playable-step mask
module hpp_step_search #(
  parameter int N = 8,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic [N-1:0]  mask,
  output logic               found,
  output logic [IW-1:0]      idx
);

  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (mask[i]) idx = IW'(i);
    end
  end

  assign found = |mask;

endmodule

`default_nettype wire

// ----- sv/haptic_pattern_player.sv -----
// channel | dir | handshake          | payload
// req     | in  | req.valid/ready    | action, step slot, step times, count, preset, intensity, supply
// rsp     | out | rsp.valid/ready    | duty, busy, suspended, accepted, last intensity, counters
// cfg     | in  | cfg_valid/ready    | supply guard in mv (cfg_ready is always high)
//
// one transaction per cycle while the receiver takes results; each result is registered in the cycle after its request
// all work happens in the accept cycle; the result register parts the two sides
// a request is taken while the held result is being taken (req.ready = !rsp.valid | rsp.ready)
// rst is synchronous and clears control state, staging store and counters
// active step store has no reset; only entries marked playable are ever read
`default_nettype none
`include "haptic_pattern_player_assert.svh"

module haptic_pattern_player #(
  parameter int MAX_STEPS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  hpp_req_if.sink          req,
  hpp_rsp_if.source        rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  logic [15:0]          guard_mv;
  logic [31:0]          staging [MAX_STEPS];
  logic [31:0]          active  [MAX_STEPS];
  logic [MAX_STEPS-1:0] act_mask;
  logic [6:0]           act_int;
  logic [IDX_W-1:0]     cur_step;
  logic [15:0]          cur_off;
  hpp_pkg::phase_t      phase;
  logic [15:0]          remaining;
  logic                 susp;
  logic [15:0]          acc_cnt;
  logic [15:0]          drop_cnt;
  logic [6:0]           seen;

  hpp_pkg::phase_t      phase_next;
  logic [15:0]          remaining_next;
  logic [IDX_W-1:0]     cur_step_next;
  logic [15:0]          cur_off_next;
  logic                 susp_next;
  logic [6:0]           act_int_next;
  logic [6:0]           seen_next;
  logic [15:0]          acc_cnt_next;
  logic [15:0]          drop_cnt_next;

  hpp_pkg::action_t     act;
  logic                 take;
  logic                 play_go;
  logic                 refused;
  logic                 play_ok;
  logic [6:0]           int_sat;
  logic [7:0]           src_count;
  logic [31:0]          src_step [MAX_STEPS];
  logic [MAX_STEPS-1:0] src_mask;
  logic [MAX_STEPS-1:0] above_mask;
  logic                 play_found;
  logic [IDX_W-1:0]     play_idx;
  logic                 next_found;
  logic [IDX_W-1:0]     next_idx;
  logic                 ent_found;
  logic [IDX_W-1:0]     ent_idx;
  logic [31:0]          ent_step;
  logic [15:0]          rem_dec;

  assign act       = hpp_pkg::action_t'(req.action);
  assign req.ready = !rsp.valid || rsp.ready;
  assign take      = req.valid && req.ready;
  assign cfg_ready = 1'b1;

  assign play_go = (act == hpp_pkg::ACT_PLAY_LOADED) ||
                   ((act == hpp_pkg::ACT_PLAY_PRESET) && (req.preset_id < hpp_pkg::PRESET_COUNT));
  assign refused = susp || ((req.supply_mv != 16'd0) && (req.supply_mv < guard_mv));
  assign play_ok = take && play_go && !refused;
  assign int_sat = (req.intensity > {1'b0, hpp_pkg::DUTY_MAX}) ? hpp_pkg::DUTY_MAX
                                                                 : req.intensity[6:0];

  // steps a play would copy in, and which of them have something to play
  assign src_count = (act == hpp_pkg::ACT_PLAY_PRESET) ? hpp_pkg::preset_len(req.preset_id)
                                                       : req.step_count;
  always_comb begin
    for (int i = 0; i < MAX_STEPS; i++) begin
      src_step[i] = (act == hpp_pkg::ACT_PLAY_PRESET) ?
                    hpp_pkg::preset_step(req.preset_id, 5'(i)) : staging[i];
      src_mask[i] = (int'(src_count) > i) && (src_step[i] != 32'd0);
      above_mask[i] = act_mask[i] && (i > int'(cur_step));
    end
  end

  hpp_step_search #(.N(MAX_STEPS)) u_play_search (
    .mask  (src_mask),
    .found (play_found),
    .idx   (play_idx)
  );

  hpp_step_search #(.N(MAX_STEPS)) u_next_search (
    .mask  (above_mask),
    .found (next_found),
    .idx   (next_idx)
  );

  // step to enter: first of a new play, or the one after the current step
  always_comb begin
    if (play_go) begin
      ent_found = play_found;
      ent_idx   = play_idx;
      ent_step  = src_step[play_idx];
    end else begin
      ent_found = next_found;
      ent_idx   = next_idx;
      ent_step  = active[next_idx];
    end
  end

  assign rem_dec = (remaining == 16'd0) ? 16'd0 : remaining - 16'd1;

  // next phase
  always_comb begin
    logic enter;
    enter          = 1'b0;
    phase_next     = phase;
    remaining_next = remaining;
    cur_step_next  = cur_step;
    cur_off_next   = cur_off;
    if (take) begin
      unique case (act)
        hpp_pkg::ACT_TICK: begin
          if (phase != hpp_pkg::PH_IDLE) begin
            if (rem_dec != 16'd0) begin
              remaining_next = rem_dec;
            end else if (phase == hpp_pkg::PH_ON && cur_off != 16'd0) begin
              phase_next     = hpp_pkg::PH_OFF;
              remaining_next = cur_off;
            end else begin
              enter = 1'b1;
            end
          end
        end
        hpp_pkg::ACT_PLAY_LOADED, hpp_pkg::ACT_PLAY_PRESET: begin
          enter = play_ok;
        end
        hpp_pkg::ACT_CANCEL, hpp_pkg::ACT_SUSPEND: begin
          phase_next     = hpp_pkg::PH_IDLE;
          remaining_next = 16'd0;
          cur_step_next  = '0;
        end
        default: begin
        end
      endcase
    end
    if (enter) begin
      if (!ent_found) begin
        phase_next     = hpp_pkg::PH_IDLE;
        remaining_next = 16'd0;
        cur_step_next  = '0;
      end else begin
        cur_step_next = ent_idx;
        cur_off_next  = ent_step[15:0];
        if (ent_step[31:16] != 16'd0) begin
          phase_next     = hpp_pkg::PH_ON;
          remaining_next = ent_step[31:16];
        end else begin
          phase_next     = hpp_pkg::PH_OFF;
          remaining_next = ent_step[15:0];
        end
      end
    end
  end

  // flags, counters and intensity
  always_comb begin
    susp_next     = susp;
    if (take && act == hpp_pkg::ACT_SUSPEND) susp_next = 1'b1;
    if (take && act == hpp_pkg::ACT_RESUME)  susp_next = 1'b0;
    act_int_next  = play_ok ? int_sat : act_int;
    seen_next     = play_ok ? int_sat : seen;
    acc_cnt_next  = acc_cnt + {15'd0, play_ok};
    drop_cnt_next = drop_cnt + {15'd0, take && play_go && refused};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      guard_mv  <= hpp_pkg::GUARD_RESET;
      act_mask  <= '0;
      act_int   <= '0;
      cur_step  <= '0;
      cur_off   <= '0;
      phase     <= hpp_pkg::PH_IDLE;
      remaining <= '0;
      susp      <= 1'b0;
      acc_cnt   <= '0;
      drop_cnt  <= '0;
      seen      <= '0;
      rsp.valid <= 1'b0;
      for (int i = 0; i < MAX_STEPS; i++) staging[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) guard_mv <= cfg_data;
      if (take && act == hpp_pkg::ACT_LOAD) begin
        for (int i = 0; i < MAX_STEPS; i++) begin
          if (int'(req.step_index) == i) staging[i] <= {req.on_time_ms, req.off_time_ms};
        end
      end
      if (play_ok) act_mask <= src_mask;
      act_int   <= act_int_next;
      cur_step  <= cur_step_next;
      cur_off   <= cur_off_next;
      phase     <= phase_next;
      remaining <= remaining_next;
      susp      <= susp_next;
      acc_cnt   <= acc_cnt_next;
      drop_cnt  <= drop_cnt_next;
      seen      <= seen_next;
      if (take) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // active store: copied whole on an accepted play
  always_ff @(posedge clk) begin
    if (play_ok) begin
      for (int i = 0; i < MAX_STEPS; i++) active[i] <= src_step[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take) begin
      rsp.duty_level     <= (phase_next == hpp_pkg::PH_ON) ? act_int_next : 7'd0;
      rsp.busy_res       <= (phase_next != hpp_pkg::PH_IDLE);
      rsp.suspended      <= susp_next;
      rsp.accepted       <= play_ok;
      rsp.last_intensity <= seen_next;
      rsp.accept_total   <= acc_cnt_next;
      rsp.refuse_total   <= drop_cnt_next;
    end
  end

  `HPP_ASSERT_NOW(a_live_phase_has_time, phase != hpp_pkg::PH_IDLE, remaining != 16'd0, "running phase with no time left")
  `HPP_ASSERT_NOW(a_duty_needs_busy, rsp.valid && rsp.duty_level != 7'd0, rsp.busy_res, "duty shown while not busy")
  `HPP_ASSERT_NOW(a_accept_not_suspended, rsp.valid && rsp.accepted, !rsp.suspended, "play accepted while suspended")
  `HPP_ASSERT_NEXT(a_suspend_stops, take && act == hpp_pkg::ACT_SUSPEND, susp && phase == hpp_pkg::PH_IDLE, "suspend did not stop pattern")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int STEP_DEPTH  = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 275;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  step_index;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [7:0]  steps;
    logic [2:0]  preset;
    logic [7:0]  intensity;
    logic [15:0] supply;
  } play_req_t;

  typedef struct packed {
    logic [6:0]  duty;
    logic        busy;
    logic        susp;
    logic        acc;
    logic [6:0]  last_level;
    logic [15:0] total;
    logic [15:0] dropped;
  } player_status_t;

  typedef struct {
    play_req_t      r;
    bit             known;
    player_status_t s;
  } table_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  hpp_req_if req_ch ();
  hpp_rsp_if rsp_ch ();

  haptic_pattern_player dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // player model state
  logic [15:0]     guard_mv;
  logic [31:0]     staged_words [STEP_DEPTH];
  logic [31:0]     active_words [STEP_DEPTH];
  int              active_len;
  logic [6:0]      play_level;
  int              step_pos;
  hpp_pkg::phase_t play_phase;
  int              ms_left;
  logic            suspend_on;
  logic [15:0]     plays_ok;
  logic [15:0]     plays_refused;
  logic [6:0]      level_seen;

  player_status_t status_q [$];
  table_row_t     directed_rows [$];
  player_status_t no_golden;

  int errors;
  int reqs_sent;
  int results_seen;
  int taken_n;
  int refused_n;
  int guard_writes;
  int burst_left;
  int quiet_cycles;
  int stall_left;
  int stall_mode;
  int cyc;

  logic           drv_known;
  player_status_t drv_golden;

  // step word: on time in the upper half, off time in the lower half
  function automatic logic [31:0] rom_word(input logic [2:0] pid, input int slot);
    logic [31:0] w;
    w = '0;
    case (pid)
      hpp_pkg::PRE_TICK:   if (slot == 0) w = {hpp_pkg::TICK_ON_MS, 16'd0};
      hpp_pkg::PRE_SHORT:  if (slot == 0) w = {hpp_pkg::SHORT_ON_MS, 16'd0};
      hpp_pkg::PRE_DOUBLE: begin
        if (slot == 0) w = {hpp_pkg::DOUBLE_ON_MS, hpp_pkg::DOUBLE_OFF_MS};
        if (slot == 1) w = {hpp_pkg::DOUBLE_ON_MS, 16'd0};
      end
      hpp_pkg::PRE_LONG:   if (slot == 0) w = {hpp_pkg::LONG_ON_MS, 16'd0};
      hpp_pkg::PRE_TRIPLE: begin
        if (slot < 2) w = {hpp_pkg::TRIPLE_ON_MS, hpp_pkg::TRIPLE_OFF_MS};
        if (slot == 2) w = {hpp_pkg::TRIPLE_ON_MS, 16'd0};
      end
      default:    w = '0;
    endcase
    return w;
  endfunction

  function automatic int rom_length(input logic [2:0] pid);
    if (pid == hpp_pkg::PRE_DOUBLE) return 2;
    if (pid == hpp_pkg::PRE_TRIPLE) return 3;
    return 1;
  endfunction

  function automatic void halt_pattern();
    play_phase = hpp_pkg::PH_IDLE;
    ms_left = 0;
    step_pos = 0;
  endfunction

  // first step at or after idx that has an on or off phase
  function automatic void enter_step(input int idx);
    int i;
    i = idx;
    while (i < active_len && i < STEP_DEPTH) begin
      step_pos = i;
      if (active_words[i][31:16] != 16'd0) begin
        play_phase = hpp_pkg::PH_ON;
        ms_left = active_words[i][31:16];
        return;
      end
      if (active_words[i][15:0] != 16'd0) begin
        play_phase = hpp_pkg::PH_OFF;
        ms_left = active_words[i][15:0];
        return;
      end
      i++;
    end
    halt_pattern();
  endfunction

  function automatic void count_down();
    if (play_phase == hpp_pkg::PH_IDLE) return;
    if (ms_left > 0) ms_left--;
    if (ms_left != 0) return;
    if (play_phase == hpp_pkg::PH_ON && active_words[step_pos][15:0] != 16'd0) begin
      play_phase = hpp_pkg::PH_OFF;
      ms_left = active_words[step_pos][15:0];
      return;
    end
    enter_step(step_pos + 1);
  endfunction

  function automatic bit start_play(input logic [31:0] src [STEP_DEPTH], input int n,
                                    input logic [7:0] lvl, input logic [15:0] mv);
    int i;
    int len;
    if (suspend_on || (mv != 16'd0 && mv < guard_mv)) begin
      plays_refused = plays_refused + 16'd1;
      refused_n++;
      return 1'b0;
    end
    len = (n > STEP_DEPTH) ? STEP_DEPTH : n;
    for (i = 0; i < STEP_DEPTH; i++) active_words[i] = (i < len) ? src[i] : 32'd0;
    active_len = len;
    play_level = (lvl > 8'd100) ? hpp_pkg::DUTY_MAX : lvl[6:0];
    level_seen = play_level;
    plays_ok = plays_ok + 16'd1;
    taken_n++;
    enter_step(0);
    return 1'b1;
  endfunction

  function automatic player_status_t step_player(input play_req_t r);
    player_status_t s;
    logic [31:0] words [STEP_DEPTH];
    bit took;
    int i;
    took = 1'b0;
    case (r.action)
      hpp_pkg::ACT_TICK:        count_down();
      hpp_pkg::ACT_LOAD:        staged_words[r.step_index] = {r.on_ms, r.off_ms};
      hpp_pkg::ACT_PLAY_LOADED: took = start_play(staged_words, r.steps, r.intensity, r.supply);
      hpp_pkg::ACT_PLAY_PRESET: begin
        // unknown preset ids leave everything as it was
        if (r.preset < hpp_pkg::PRESET_COUNT) begin
          for (i = 0; i < STEP_DEPTH; i++) words[i] = rom_word(r.preset, i);
          took = start_play(words, rom_length(r.preset), r.intensity, r.supply);
        end
      end
      hpp_pkg::ACT_CANCEL:      halt_pattern();
      hpp_pkg::ACT_SUSPEND: begin
        suspend_on = 1'b1;
        halt_pattern();
      end
      hpp_pkg::ACT_RESUME:      suspend_on = 1'b0;
      default:         ;
    endcase
    s.duty = (play_phase == hpp_pkg::PH_ON) ? play_level : 7'd0;
    s.busy = (play_phase != hpp_pkg::PH_IDLE);
    s.susp = suspend_on;
    s.acc = took;
    s.last_level = level_seen;
    s.total = plays_ok;
    s.dropped = plays_refused;
    return s;
  endfunction

  function automatic play_req_t rq(input logic [2:0] a, input logic [2:0] idx,
                                   input logic [15:0] on, input logic [15:0] off,
                                   input logic [7:0] n, input logic [2:0] pid,
                                   input logic [7:0] lvl, input logic [15:0] mv);
    return '{a, idx, on, off, n, pid, lvl, mv};
  endfunction

  function automatic player_status_t st(input logic [6:0] duty, input logic busy,
                                        input logic susp, input logic acc,
                                        input logic [6:0] lvl, input logic [15:0] total,
                                        input logic [15:0] dropped);
    return '{duty, busy, susp, acc, lvl, total, dropped};
  endfunction

  function automatic void add_known(input play_req_t r, input player_status_t s);
    table_row_t row;
    row.r = r;
    row.known = 1'b1;
    row.s = s;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_open(input play_req_t r);
    table_row_t row;
    row.r = r;
    row.known = 1'b0;
    row.s = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic play_req_t random_req();
    play_req_t r;
    r.action = $urandom_range(0, 7);
    r.step_index = $urandom_range(0, 7);
    r.on_ms = $urandom_range(0, 65535);
    r.off_ms = $urandom_range(0, 65535);
    r.steps = $urandom_range(0, 255);
    r.preset = $urandom_range(0, 7);
    r.intensity = $urandom_range(0, 255);
    r.supply = $urandom_range(0, 65535);
    return r;
  endfunction

  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      8:       return $urandom_range(7, 40);
      9:       return $urandom_range(0, 65535);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // half the picks land right around the guard, where admission flips
  function automatic logic [15:0] pick_supply();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return guard_mv - 16'd1;
      2:       return guard_mv;
      3:       return guard_mv + 16'd1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic drive_request(input play_req_t r, input bit known,
                               input player_status_t g);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.step_index <= r.step_index;
    req_ch.on_time_ms <= r.on_ms;
    req_ch.off_time_ms <= r.off_ms;
    req_ch.step_count <= r.steps;
    req_ch.preset_id <= r.preset;
    req_ch.intensity <= r.intensity;
    req_ch.supply_mv <= r.supply;
    drv_known <= known;
    drv_golden <= g;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    reqs_sent++;
  endtask

  task automatic send_rand(input play_req_t r);
    drive_request(r, 1'b0, no_golden);
  endtask

  // an optional resume, loads, one play, then ticks to walk through the pattern, up to the item budget
  task automatic run_pattern(input int limit);
    play_req_t r;
    int n;
    int k;
    if (suspend_on && $urandom_range(0, 1) == 1) begin
      r = random_req();
      r.action = hpp_pkg::ACT_RESUME;
      send_rand(r);
    end
    n = $urandom_range(0, 4);
    for (k = 0; k < n; k++) begin
      r = random_req();
      r.action = hpp_pkg::ACT_LOAD;
      r.on_ms = pick_time();
      r.off_ms = pick_time();
      send_rand(r);
    end
    r = random_req();
    if ($urandom_range(0, 9) < 6) begin
      r.action = hpp_pkg::ACT_PLAY_LOADED;
      case ($urandom_range(0, 9))
        8:       r.steps = 8'd0;
        9:       r.steps = $urandom_range(0, 255);
        default: r.steps = $urandom_range(0, 8);
      endcase
    end else begin
      r.action = hpp_pkg::ACT_PLAY_PRESET;
      r.preset = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 7);
    end
    r.intensity = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 100) : $urandom_range(0, 255);
    r.supply = pick_supply();
    send_rand(r);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 650) : $urandom_range(1, 30);
    for (k = 0; k < n && reqs_sent < limit; k++) begin
      r = random_req();
      r.action = hpp_pkg::ACT_TICK;
      send_rand(r);
    end
  endtask

  task automatic run_noise();
    play_req_t r;
    r = random_req();
    r.supply = pick_supply();
    send_rand(r);
    if (r.action == hpp_pkg::ACT_SUSPEND) begin
      // a play while suspended must be refused
      r = random_req();
      r.action = ($urandom_range(0, 1) == 1) ? hpp_pkg::ACT_PLAY_LOADED
                                             : hpp_pkg::ACT_PLAY_PRESET;
      send_rand(r);
      if ($urandom_range(0, 3) != 0) begin
        r = random_req();
        r.action = hpp_pkg::ACT_RESUME;
        send_rand(r);
      end
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = reqs_sent + n;
    while (reqs_sent < target) begin
      if ($urandom_range(0, 9) < 7) run_pattern(target);
      else run_noise();
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_guard(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    guard_mv = v;
    guard_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // prediction on request, comparison on result
  always @(posedge clk) begin
    play_req_t      mon_req;
    player_status_t pred;
    player_status_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (status_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("duty_level", want.duty, rsp_ch.duty_level);
          check_field("busy_res", want.busy, rsp_ch.busy_res);
          check_field("suspended", want.susp, rsp_ch.suspended);
          check_field("accepted", want.acc, rsp_ch.accepted);
          check_field("last_intensity", want.last_level, rsp_ch.last_intensity);
          check_field("accept_total", want.total, rsp_ch.accept_total);
          check_field("refuse_total", want.dropped, rsp_ch.refuse_total);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        mon_req = '{req_ch.action, req_ch.step_index, req_ch.on_time_ms, req_ch.off_time_ms,
                    req_ch.step_count, req_ch.preset_id, req_ch.intensity, req_ch.supply_mv};
        pred = step_player(mon_req);
        status_q.push_back(drv_known ? drv_golden : pred);
      end
    end
  end

  // receiver: switches between stall patterns every so often
  always @(negedge clk) begin
    cyc++;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    case (stall_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
      2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ch.ready <= ((cyc % 8) < 5);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] guard_plan [4];
    int i;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.action = hpp_pkg::ACT_TICK;
    req_ch.step_index = '0;
    req_ch.on_time_ms = '0;
    req_ch.off_time_ms = '0;
    req_ch.step_count = '0;
    req_ch.preset_id = '0;
    req_ch.intensity = '0;
    req_ch.supply_mv = '0;
    rsp_ch.ready = 1'b0;
    drv_known = 1'b0;
    drv_golden = '0;
    no_golden = '0;
    errors = 0;
    reqs_sent = 0;
    results_seen = 0;
    taken_n = 0;
    refused_n = 0;
    guard_writes = 0;
    burst_left = 0;
    quiet_cycles = 0;
    stall_left = 0;
    stall_mode = 0;
    cyc = 0;

    guard_mv = hpp_pkg::GUARD_RESET;
    for (i = 0; i < STEP_DEPTH; i++) begin
      staged_words[i] = '0;
      active_words[i] = '0;
    end
    active_len = 0;
    play_level = '0;
    suspend_on = 1'b0;
    plays_ok = '0;
    plays_refused = '0;
    level_seen = '0;
    halt_pattern();

    // idle, unused code, a short mixed pattern, presets, admission edges, suspend and resume
    add_known(rq(hpp_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0), st(0, 0, 0, 0, 0, 0, 0));
    add_known(rq(3'd7, 0, 0, 0, 0, 0, 0, 0), st(0, 0, 0, 0, 0, 0, 0));
    add_known(rq(hpp_pkg::ACT_LOAD, 0, 1, 1, 0, 0, 0, 0), st(0, 0, 0, 0, 0, 0, 0));
    add_known(rq(hpp_pkg::ACT_LOAD, 1, 0, 0, 0, 0, 0, 0), st(0, 0, 0, 0, 0, 0, 0));
    add_known(rq(hpp_pkg::ACT_LOAD, 2, 0, 1, 0, 0, 0, 0), st(0, 0, 0, 0, 0, 0, 0));
    add_known(rq(hpp_pkg::ACT_LOAD, 3, 1, 0, 0, 0, 0, 0), st(0, 0, 0, 0, 0, 0, 0));
    add_known(rq(hpp_pkg::ACT_PLAY_LOADED, 0, 0, 0, 4, 0, 255, 0),
              st(100, 1, 0, 1, 100, 1, 0));
    for (i = 0; i < 4; i++) add_open(rq(hpp_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    add_known(rq(hpp_pkg::ACT_PLAY_PRESET, 0, 0, 0, 0, 7, 50, 5000),
              st(0, 0, 0, 0, 100, 1, 0));
    add_known(rq(hpp_pkg::ACT_PLAY_PRESET, 0, 0, 0, 0, hpp_pkg::PRE_TICK, 0, 65535),
              st(0, 1, 0, 1, 0, 2, 0));
    add_known(rq(hpp_pkg::ACT_PLAY_PRESET, 0, 0, 0, 0, hpp_pkg::PRE_TRIPLE, 100, 3299),
              st(0, 1, 0, 0, 0, 2, 1));
    add_known(rq(hpp_pkg::ACT_PLAY_PRESET, 0, 0, 0, 0, hpp_pkg::PRE_DOUBLE, 101, 3300),
              st(100, 1, 0, 1, 100, 3, 1));
    add_known(rq(hpp_pkg::ACT_CANCEL, 0, 0, 0, 0, 0, 0, 0), st(0, 0, 0, 0, 100, 3, 1));
    add_open(rq(hpp_pkg::ACT_LOAD, 7, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
    add_open(rq(hpp_pkg::ACT_PLAY_LOADED, 0, 0, 0, 255, 0, 50, 65535));
    add_open(rq(hpp_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
    add_known(rq(hpp_pkg::ACT_SUSPEND, 0, 0, 0, 0, 0, 0, 0), st(0, 0, 1, 0, 50, 4, 1));
    add_known(rq(hpp_pkg::ACT_PLAY_PRESET, 0, 0, 0, 0, hpp_pkg::PRE_LONG, 80, 0),
              st(0, 0, 1, 0, 50, 4, 2));
    add_known(rq(hpp_pkg::ACT_RESUME, 0, 0, 0, 0, 0, 0, 0), st(0, 0, 0, 0, 50, 4, 2));
    add_open(rq(hpp_pkg::ACT_PLAY_LOADED, 0, 0, 0, 0, 0, 7, 4000));
    add_open(rq(hpp_pkg::ACT_PLAY_PRESET, 0, 0, 0, 0, hpp_pkg::PRE_SHORT, 100, 3301));
    add_open(rq(hpp_pkg::ACT_PLAY_PRESET, 0, 0, 0, 0, hpp_pkg::PRE_LONG, 30, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[k]) drive_request(directed_rows[k].r, directed_rows[k].known,
                                             directed_rows[k].s);
    run_random(PHASE_ITEMS);

    guard_plan[0] = 16'd0;
    guard_plan[1] = 16'hFFFF;
    guard_plan[2] = $urandom_range(1, 65534);
    guard_plan[3] = hpp_pkg::GUARD_RESET;
    for (i = 0; i < 4; i++) begin
      drain_results();
      write_guard(guard_plan[i]);
      run_random(PHASE_ITEMS);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (status_q.size() != 0) begin
      $error("%0d expected results never arrived", status_q.size());
      errors++;
    end
    $display("%0d requests, %0d results checked across %0d supply guard settings",
             reqs_sent, results_seen, guard_writes + 1);
    $display("plays taken %0d, plays refused %0d, mismatches %0d",
             taken_n, refused_n, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
